FILE: sv/edf_pkg.sv
// package for the edf periodic task scheduler
// holds widths, register codes, reset values and the configuration struct
// no dependencies
package edf_pkg;

	localparam int NUM_TASKS = 4;
	localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

	localparam int TC_W      = 3;
	localparam int TIMING_W  = 48;
	localparam int FIELD_W   = 16;
	localparam int DL_W      = 17;
	localparam int TICK_W    = 32;
	localparam int RUN_W     = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [TIMING_W-1:0] TIMING_RESET = 48'h0001_0001_0000;
	localparam logic [TC_W-1:0]     TC_RESET     = 3'd1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TASK_COUNT   = 3'd0,
		REG_TASK0_TIMING = 3'd1,
		REG_TASK1_TIMING = 3'd2,
		REG_TASK2_TIMING = 3'd3,
		REG_TASK3_TIMING = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [TC_W-1:0]                    task_count;
		logic [NUM_TASKS-1:0][TIMING_W-1:0] timing;
	} edf_cfg_t;

endpackage

FILE: sv/edf_if.sv
// channel interfaces of the edf scheduler: tick input, result output, config write
// depends on edf_pkg
interface edf_in_if import edf_pkg::*; ();
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface edf_out_if import edf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RUN_W-1:0]  running_task;
	logic             idle;
	logic [TICK_W-1:0] tick_number;

	modport source (output valid, output running_task, output idle, output tick_number,
		input ready);
	modport sink (input valid, input running_task, input idle, input tick_number,
		output ready);
endinterface

interface edf_cfg_if import edf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TIMING_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/edf_cfg_regs.sv
// configuration register file of the edf scheduler: task count and per-task timing
// depends on edf_pkg and edf_cfg_if
module edf_cfg_regs import edf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	edf_cfg_if.sink       cfg,
	output edf_cfg_t      regs
);

	logic [TC_W-1:0]                    task_count_q;
	logic [NUM_TASKS-1:0][TIMING_W-1:0] timing_q;
	logic                               wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= TC_RESET;
			for (int i = 0; i < NUM_TASKS; i++) begin
				timing_q[i] <= TIMING_RESET;
			end
		end else if (wr) begin
			if (cfg.index == REG_TASK_COUNT) begin
				task_count_q <= cfg.data[TC_W-1:0];
			end
			// indexes past the last timing register are dropped
			for (int i = 0; i < NUM_TASKS; i++) begin
				if ({29'd0, cfg.index} == 32'(int'(REG_TASK0_TIMING) + i)) begin
					timing_q[i] <= cfg.data;
				end
			end
		end
	end

	assign regs.task_count = task_count_q;
	assign regs.timing     = timing_q;

endmodule

FILE: sv/edf_periodic_task_scheduler_core.sv
// top level of the edf periodic task scheduler
// depends on edf_pkg, edf_if.sv and edf_cfg_regs
//
// One input word is one scheduler tick and gives one result word. A tick is
// taken in the idle state, then a single compare/update unit visits the tasks
// in use one per cycle (release, earliest-deadline compare, phase and deadline
// advance), and a done state then retires the winner's work and loads the
// result register. From 1 to 4 tasks are in use. The result register lets a
// new tick be taken while the previous result still waits; the final retire
// step of the next tick waits only if that result has not yet been taken by
// then. Configuration writes are taken every cycle and must only come while
// no tick is in flight.
module edf_periodic_task_scheduler_core import edf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	edf_in_if.sink     in_ch,
	edf_out_if.source  out_ch,
	edf_cfg_if.sink    cfg
);

	// sequencer: wait for tick, walk tasks, commit result
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	edf_cfg_t regs;

	edf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     last_idx;

	// per-task state
	logic [FIELD_W-1:0]   phase_q    [NUM_TASKS];
	logic [FIELD_W-1:0]   work_q     [NUM_TASKS];
	logic [DL_W-1:0]      deadline_q [NUM_TASKS];
	logic [TICK_W-1:0]    tick_q;

	// running best of the walk
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [DL_W-1:0]      best_dl_q;
	logic [FIELD_W-1:0]   best_work_q;

	// result register
	logic                 out_valid_q;
	logic [RUN_W-1:0]     out_task_q;
	logic                 out_idle_q;
	logic [TICK_W-1:0]    out_tick_q;

	// shared unit inputs, the task under the walk pointer
	logic [TIMING_W-1:0]  cur_timing;
	logic [FIELD_W-1:0]   cur_burst;
	logic [FIELD_W-1:0]   cur_period;
	logic                 released;
	logic [FIELD_W-1:0]   cur_work;
	logic [DL_W-1:0]      cur_dl;
	logic                 better;
	logic [FIELD_W:0]     phase_inc;
	logic [FIELD_W-1:0]   period_eff;
	logic [FIELD_W-1:0]   phase_next;
	logic [DL_W-1:0]      dl_next;

	logic                 in_take;
	logic                 out_free;
	logic                 out_load;

	assign in_take  = in_ch.valid & in_ch.ready;
	assign out_free = ~out_valid_q | out_ch.ready;
	assign out_load = (state_q == S_DONE) & out_free;

	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.running_task = out_task_q;
	assign out_ch.idle         = out_idle_q;
	assign out_ch.tick_number  = out_tick_q;

	// last task in use: 0 counts as one task, large values clamp to all tasks
	always_comb begin
		if (regs.task_count == '0) begin
			last_idx = '0;
		end else if (32'(regs.task_count) > NUM_TASKS) begin
			last_idx = IDX_W'(NUM_TASKS - 1);
		end else begin
			last_idx = IDX_W'(regs.task_count - TC_W'(1));
		end
	end

	// release, compare and time advance for the current task
	always_comb begin
		cur_timing = regs.timing[idx_q];
		cur_burst  = cur_timing[15:0];
		cur_period = cur_timing[47:32];
		released   = (phase_q[idx_q] == '0);
		cur_work   = released ? cur_burst : work_q[idx_q];
		cur_dl     = released ? {1'b0, cur_timing[31:16]} : deadline_q[idx_q];
		// strict less-than keeps the lowest index on ties
		better     = (cur_work != '0) && (!found_q || (cur_dl < best_dl_q));
		period_eff = (cur_period == '0) ? FIELD_W'(1) : cur_period;
		phase_inc  = {1'b0, phase_q[idx_q]} + (FIELD_W+1)'(1);
		phase_next = (phase_inc >= {1'b0, period_eff}) ? '0 : phase_inc[FIELD_W-1:0];
		// countdown saturates at zero
		dl_next    = (cur_dl != '0) ? cur_dl - DL_W'(1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			tick_q      <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				phase_q[i]    <= '0;
				work_q[i]     <= '0;
				deadline_q[i] <= '0;
			end
		end else begin
			// a new result replaces the one taken in the same cycle
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (in_ch.restart) begin
							tick_q <= '0;
							for (int i = 0; i < NUM_TASKS; i++) begin
								phase_q[i] <= '0;
							end
						end
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (released) begin
						work_q[idx_q] <= cur_burst;
					end
					deadline_q[idx_q] <= dl_next;
					phase_q[idx_q]    <= phase_next;
					if (better) begin
						found_q <= 1'b1;
					end
					if (idx_q == last_idx) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (found_q) begin
							work_q[best_idx_q] <= best_work_q - FIELD_W'(1);
						end
						if (tick_q != '1) begin
							tick_q <= tick_q + TICK_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// best-candidate and result payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && better) begin
			best_idx_q  <= idx_q;
			best_dl_q   <= cur_dl;
			best_work_q <= cur_work;
		end
		if (out_load) begin
			out_task_q <= found_q ? RUN_W'(best_idx_q) : '0;
			out_idle_q <= ~found_q;
			out_tick_q <= tick_q;
		end
	end

endmodule
